FILE: sv/priority_voice_allocator_unit_macros.svh
// assertion macros for the priority voice allocator
// used by priority_voice_allocator_unit, needs clk_i and rst_ni in scope
`ifndef PRIORITY_VOICE_ALLOCATOR_UNIT_MACROS_SVH
`define PRIORITY_VOICE_ALLOCATOR_UNIT_MACROS_SVH

// property that holds in every cycle out of reset
`define PVA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// consequent checked in the cycle after the antecedent
`define PVA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/pva_pkg.sv
// shared types and constants of the priority voice allocator
// used by pva_cell and priority_voice_allocator_unit
package pva_pkg;

  localparam int MaxVoices = 16;
  localparam int IdxW      = (MaxVoices > 1) ? $clog2(MaxVoices) : 1;
  localparam int CntW      = $clog2(MaxVoices + 1);
  localparam int CfgW      = 5;
  localparam int IdW       = 16;
  localparam int PriW      = 16;
  localparam int PayW      = 32;
  localparam logic [CfgW-1:0] ChanReset = CfgW'(16);

  typedef enum logic [2:0] {
    ActBegin  = 3'd0,
    ActStart  = 3'd1,
    ActUpdate = 3'd2,
    ActStop   = 3'd3,
    ActEnd    = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    StsOk           = 2'd0,
    StsOutsideFrame = 2'd1,
    StsBeginInFrame = 2'd2,
    StsZeroId       = 2'd3
  } status_e;

  // slot write broadcast to all cells
  typedef struct packed {
    logic            we;
    logic [IdxW-1:0] slot;
    logic [IdW-1:0]  id;
    logic [PriW-1:0] pri;
    logic [PayW-1:0] payload;
    logic            mark;
  } wr_t;

  // running min and max carried down the chain
  typedef struct packed {
    logic            vld;
    logic [IdxW-1:0] min_idx;
    logic [PriW-1:0] min_pri;
    logic [IdxW-1:0] max_idx;
    logic [IdW-1:0]  max_id;
    logic [PriW-1:0] max_pri;
  } scan_t;

endpackage

FILE: sv/priority_voice_allocator_unit.sv
// Priority voice allocator: a row of MAX_VOICES slot cells with a min/max scan that
// ripples one cell per cycle. For each item the slot is decided and written when the
// item is taken, then the scan runs down the chain of cells to its end, then the result
// is registered in the output register once that register is free to take it.
// A new item is taken once the previous one has reached the output register.
// Top level; depends on pva_pkg, pva_cell and priority_voice_allocator_unit_macros.svh.
`include "priority_voice_allocator_unit_macros.svh"

module priority_voice_allocator_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  action_i,
  input  logic [15:0] sound_id_i,
  input  logic [15:0] priority_req_i,
  input  logic [31:0] payload_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic        accepted_o,
  output logic [3:0]  slot_index_o,
  output logic        evicted_o,
  output logic [4:0]  voice_count_o,
  output logic        top_valid_o,
  output logic [3:0]  top_slot_o,
  output logic [15:0] top_id_o,
  output logic [15:0] top_priority_o
);

  localparam int N    = pva_pkg::MaxVoices;
  localparam int IdxW = pva_pkg::IdxW;
  localparam int CntW = pva_pkg::CntW;
  localparam int CmpW = (pva_pkg::CntW > pva_pkg::CfgW) ? pva_pkg::CntW : pva_pkg::CfgW;

  typedef enum logic {StIdle, StScan} state_e;

  typedef struct packed {
    logic [1:0]  status;
    logic        accepted;
    logic [3:0]  slot_index;
    logic        evicted;
    logic [4:0]  voice_count;
    logic        top_valid;
    logic [3:0]  top_slot;
    logic [15:0] top_id;
    logic [15:0] top_priority;
  } result_t;

  state_e                   state_q;
  logic [CntW-1:0]          cnt_q;
  logic [pva_pkg::CfgW-1:0] chan_q;
  logic [CntW-1:0]          fill_q, fill_d;
  logic                     frame_q, frame_d;
  logic [IdxW-1:0]          low_idx_q;
  logic [pva_pkg::PriW-1:0] low_pri_q;
  pva_pkg::status_e         st_q, st_d;
  logic                     acc_q, acc_d;
  logic [IdxW-1:0]          slot_q, slot_d;
  logic                     ev_q, ev_d;
  result_t                  res_q;
  logic                     out_valid_q;

  pva_pkg::action_e         act;
  logic [CmpW-1:0]          cap;
  logic                     fill_lt_cap;
  logic                     in_xfer;
  logic                     finish;
  pva_pkg::wr_t             wr;
  pva_pkg::scan_t           chain [N+1];

  assign in_ready_o = (state_q == StIdle);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign finish     = (state_q == StScan) && (cnt_q == CntW'(N)) &&
                      (!out_valid_q || out_ready_i);

  assign act         = pva_pkg::action_e'(action_i);
  assign cap         = (CmpW'(chan_q) > CmpW'(N)) ? CmpW'(N) : CmpW'(chan_q);
  assign fill_lt_cap = CmpW'(fill_q) < cap;

  always_comb begin
    st_d    = pva_pkg::StsOk;
    acc_d   = 1'b0;
    slot_d  = '0;
    ev_d    = 1'b0;
    fill_d  = fill_q;
    frame_d = frame_q;
    unique case (act)
      pva_pkg::ActBegin: begin
        if (frame_q) begin
          st_d = pva_pkg::StsBeginInFrame;
        end else begin
          frame_d = 1'b1;
          fill_d  = '0;
        end
      end
      pva_pkg::ActStart, pva_pkg::ActUpdate, pva_pkg::ActStop, pva_pkg::ActEnd: begin
        priority if (!frame_q) begin
          st_d = pva_pkg::StsOutsideFrame;
        end else if (act == pva_pkg::ActEnd) begin
          frame_d = 1'b0;
        end else if (sound_id_i == '0) begin
          st_d = pva_pkg::StsZeroId;
        end else if (act != pva_pkg::ActStop) begin
          if (fill_lt_cap) begin
            slot_d = IdxW'(fill_q);
            fill_d = fill_q + 1'b1;
            acc_d  = 1'b1;
          end else if ((fill_q != '0) && (low_pri_q < priority_req_i)) begin
            slot_d = low_idx_q;
            acc_d  = 1'b1;
            ev_d   = 1'b1;
          end
        end else begin
          // stop leaves the table as it is
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    wr.we      = in_xfer && acc_d;
    wr.slot    = slot_d;
    wr.id      = sound_id_i;
    wr.pri     = priority_req_i;
    wr.payload = payload_i;
    wr.mark    = (act == pva_pkg::ActUpdate);
  end

  assign chain[0] = '0;

  for (genvar i = 0; i < N; i++) begin : g_cell
    pva_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .idx_i  (IdxW'(i)),
      .fill_i (fill_q),
      .wr_i   (wr),
      .scan_i (chain[i]),
      .scan_o (chain[i+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      chan_q      <= pva_pkg::ChanReset;
      fill_q      <= '0;
      frame_q     <= 1'b0;
      low_idx_q   <= '0;
      low_pri_q   <= '0;
      st_q        <= pva_pkg::StsOk;
      acc_q       <= 1'b0;
      slot_q      <= '0;
      ev_q        <= 1'b0;
      res_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        chan_q <= cfg_wdata_i;
      end
      if (out_valid_q && out_ready_i && !finish) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (in_xfer) begin
            fill_q  <= fill_d;
            frame_q <= frame_d;
            st_q    <= st_d;
            acc_q   <= acc_d;
            slot_q  <= slot_d;
            ev_q    <= ev_d;
            cnt_q   <= '0;
            state_q <= StScan;
          end
        end
        StScan: begin
          if (cnt_q != CntW'(N)) begin
            cnt_q <= cnt_q + 1'b1;
          end
          if (finish) begin
            low_idx_q                <= chain[N].vld ? chain[N].min_idx : '0;
            low_pri_q                <= chain[N].min_pri;
            res_q.status             <= st_q;
            res_q.accepted           <= acc_q;
            res_q.slot_index         <= 4'(slot_q);
            res_q.evicted            <= ev_q;
            res_q.voice_count        <= 5'(fill_q);
            res_q.top_valid          <= chain[N].vld;
            res_q.top_slot           <= chain[N].vld ? 4'(chain[N].max_idx) : '0;
            res_q.top_id             <= chain[N].vld ? chain[N].max_id : '0;
            res_q.top_priority       <= chain[N].vld ? chain[N].max_pri : '0;
            out_valid_q              <= 1'b1;
            state_q                  <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = res_q.status;
  assign accepted_o     = res_q.accepted;
  assign slot_index_o   = res_q.slot_index;
  assign evicted_o      = res_q.evicted;
  assign voice_count_o  = res_q.voice_count;
  assign top_valid_o    = res_q.top_valid;
  assign top_slot_o     = res_q.top_slot;
  assign top_id_o       = res_q.top_id;
  assign top_priority_o = res_q.top_priority;

  `PVA_ASSERT(a_fill_bound, fill_q <= CntW'(N), "fill count above slot count")
  `PVA_ASSERT_NEXT(a_busy_after_xfer, in_xfer, !in_ready_o, "input taken while scan pending")
  `PVA_ASSERT(a_evict_needs_accept, !(out_valid_o && evicted_o) || accepted_o,
              "eviction reported without acceptance")
  `PVA_ASSERT(a_slot_in_table, !(out_valid_o && accepted_o) || (slot_index_o < voice_count_o),
              "accepted slot outside occupied range")
  `PVA_ASSERT(a_top_matches_count, !out_valid_o || (top_valid_o == (voice_count_o != '0)),
              "top valid disagrees with voice count")

endmodule

FILE: sv/pva_cell.sv
// one voice slot: stored voice plus one stage of the min/max scan chain
// depends on pva_pkg
module pva_cell (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [pva_pkg::IdxW-1:0] idx_i,
  input  logic [pva_pkg::CntW-1:0] fill_i,
  input  pva_pkg::wr_t             wr_i,
  input  pva_pkg::scan_t           scan_i,
  output pva_pkg::scan_t           scan_o
);

  logic [pva_pkg::IdW-1:0]  id_q;
  logic [pva_pkg::PriW-1:0] pri_q;
  logic [pva_pkg::PayW-1:0] pay_q;
  logic                     mark_q;
  pva_pkg::scan_t           scan_d, scan_q;
  logic                     active;

  always_ff @(posedge clk_i) begin
    if (wr_i.we && (wr_i.slot == idx_i)) begin
      id_q   <= wr_i.id;
      pri_q  <= wr_i.pri;
      pay_q  <= wr_i.payload;
      mark_q <= wr_i.mark;
    end
  end

  assign active = pva_pkg::CntW'(idx_i) < fill_i;

  always_comb begin
    scan_d = scan_i;
    if (active) begin
      scan_d.vld = 1'b1;
      if (!scan_i.vld || (pri_q < scan_i.min_pri)) begin
        scan_d.min_idx = idx_i;
        scan_d.min_pri = pri_q;
      end
      if (!scan_i.vld || (scan_i.max_pri < pri_q)) begin
        scan_d.max_idx = idx_i;
        scan_d.max_id  = id_q;
        scan_d.max_pri = pri_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q <= '0;
    end else begin
      scan_q <= scan_d;
    end
  end

  assign scan_o = scan_q;

endmodule

FILE: tb/priority_voice_allocator_checker.sv
// checker for priority_voice_allocator_unit: watches the config port and both channels,
// keeps its own copy of the voice table and compares every result transfer in order
// depends on pva_pkg
module priority_voice_allocator_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [2:0]  action_i,
  input  logic [15:0] sound_id_i,
  input  logic [15:0] priority_req_i,
  input  logic [31:0] payload_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [1:0]  status_i,
  input  logic        accepted_i,
  input  logic [3:0]  slot_index_i,
  input  logic        evicted_i,
  input  logic [4:0]  voice_count_i,
  input  logic        top_valid_i,
  input  logic [3:0]  top_slot_i,
  input  logic [15:0] top_id_i,
  input  logic [15:0] top_priority_i,
  output int          fails_o,
  output int          pending_o
);

  typedef struct packed {
    pva_pkg::status_e         status;
    logic                     accepted;
    logic [3:0]               slot;
    logic                     evicted;
    logic [4:0]               count;
    logic                     top_valid;
    logic [3:0]               top_slot;
    logic [pva_pkg::IdW-1:0]  top_id;
    logic [pva_pkg::PriW-1:0] top_pri;
  } voice_result_t;

  logic [pva_pkg::IdW-1:0]  tbl_id   [pva_pkg::MaxVoices];
  logic [pva_pkg::PriW-1:0] tbl_pri  [pva_pkg::MaxVoices];
  logic [pva_pkg::PayW-1:0] tbl_pay  [pva_pkg::MaxVoices];
  logic                     tbl_mark [pva_pkg::MaxVoices];
  logic [4:0]               used_slots;
  logic [3:0]               weakest_slot;
  logic                     frame_live;
  logic [pva_pkg::CfgW-1:0] channel_limit;

  voice_result_t   results_q[$];
  voice_result_t   want;
  voice_result_t   got;

  initial fails_o = 0;

  task automatic report_mismatch(input string msg);
    if (fails_o < 40) $display("[%0t] mismatch: %s", $time, msg);
    fails_o++;
  endtask

  task automatic check_field(input string name, input int unsigned seen, input int unsigned ref_v);
    if (seen != ref_v) report_mismatch($sformatf("%s got %0d expected %0d", name, seen, ref_v));
  endtask

  // applies one voice event to the table copy and returns the result it should produce
  function automatic voice_result_t allocate_voice(input logic [2:0] act,
                                                   input logic [15:0] sid,
                                                   input logic [15:0] pri,
                                                   input logic [31:0] pay);
    voice_result_t r;
    logic [4:0]    cap;
    int            best;
    r = '0;
    r.status = pva_pkg::StsOk;
    cap = (channel_limit > pva_pkg::MaxVoices) ? 5'(pva_pkg::MaxVoices) : channel_limit;
    if (act == pva_pkg::ActBegin) begin
      if (frame_live) begin
        r.status = pva_pkg::StsBeginInFrame;
      end else begin
        frame_live = 1'b1;
        used_slots = '0;
        weakest_slot = '0;
      end
    end else if (act <= pva_pkg::ActEnd) begin
      if (!frame_live) begin
        r.status = pva_pkg::StsOutsideFrame;
      end else if (act == pva_pkg::ActEnd) begin
        frame_live = 1'b0;
      end else if (sid == '0) begin
        r.status = pva_pkg::StsZeroId;
      end else if (act != pva_pkg::ActStop) begin
        if (used_slots < cap) begin
          r.slot = used_slots[3:0];
          used_slots++;
          r.accepted = 1'b1;
        end else if (used_slots > 0 && tbl_pri[weakest_slot] < pri) begin
          r.slot = weakest_slot;
          r.accepted = 1'b1;
          r.evicted = 1'b1;
        end
        if (r.accepted) begin
          tbl_id[r.slot] = sid;
          tbl_pri[r.slot] = pri;
          tbl_pay[r.slot] = pay;
          tbl_mark[r.slot] = (act == pva_pkg::ActUpdate);
          best = 0;
          for (int i = 1; i < used_slots; i++) if (tbl_pri[i] < tbl_pri[best]) best = i;
          weakest_slot = 4'(best);
        end
      end
    end
    r.count = used_slots;
    if (used_slots != 0) begin
      best = 0;
      for (int i = 1; i < used_slots; i++) if (tbl_pri[best] < tbl_pri[i]) best = i;
      r.top_valid = 1'b1;
      r.top_slot = 4'(best);
      r.top_id = tbl_id[best];
      r.top_pri = tbl_pri[best];
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_slots = '0;
      weakest_slot = '0;
      frame_live = 1'b0;
      channel_limit = pva_pkg::ChanReset;
      results_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) channel_limit = cfg_wdata_i;
      if (in_valid_i && in_ready_i) begin
        results_q.push_back(allocate_voice(action_i, sound_id_i, priority_req_i, payload_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (results_q.size() == 0) begin
          report_mismatch("result transfer with no event waiting");
        end else begin
          want = results_q.pop_front();
          got = '{pva_pkg::status_e'(status_i), accepted_i, slot_index_i, evicted_i,
                  voice_count_i, top_valid_i, top_slot_i, top_id_i, top_priority_i};
          check_field("status", got.status, want.status);
          check_field("accepted", got.accepted, want.accepted);
          check_field("slot_index", got.slot, want.slot);
          check_field("evicted", got.evicted, want.evicted);
          check_field("voice_count", got.count, want.count);
          check_field("top_valid", got.top_valid, want.top_valid);
          check_field("top_slot", got.top_slot, want.top_slot);
          check_field("top_id", got.top_id, want.top_id);
          check_field("top_priority", got.top_pri, want.top_pri);
        end
      end
      pending_o <= results_q.size();
    end
  end

endmodule

FILE: tb/priority_voice_allocator_unit_tb.sv
// testbench top for priority_voice_allocator_unit: directed and random voice events
// with bursty input, stalling output and several channel settings
// depends on pva_pkg, priority_voice_allocator_unit and priority_voice_allocator_checker
module priority_voice_allocator_unit_tb;

  localparam int ItemTarget = 1750;
  localparam int ItemCycles = pva_pkg::MaxVoices + 2;
  localparam int CycleLimit = 600000;
  localparam int HoldCycles = 400;
  localparam int HoldAtItem = 600;
  localparam logic [2:0] ActUnusedLo = 3'd5;
  localparam logic [2:0] ActUnusedHi = 3'd7;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [4:0]  cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic [2:0]  action_i = '0;
  logic [15:0] sound_id_i = '0;
  logic [15:0] priority_req_i = '0;
  logic [31:0] payload_i = '0;
  logic        out_ready_i = 1'b0;
  logic        in_ready_o;
  logic        out_valid_o;
  logic [1:0]  status_o;
  logic        accepted_o;
  logic [3:0]  slot_index_o;
  logic        evicted_o;
  logic [4:0]  voice_count_o;
  logic        top_valid_o;
  logic [3:0]  top_slot_o;
  logic [15:0] top_id_o;
  logic [15:0] top_priority_o;

  int          fails;
  int          pending;
  int unsigned cycle_count = 0;
  int          items_sent = 0;
  int          burst_left = 0;
  bit          no_gaps = 1'b0;
  bit          hold_go = 1'b0;
  bit          hold_used = 1'b0;

  priority_voice_allocator_unit dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o, .action_i, .sound_id_i, .priority_req_i, .payload_i,
    .out_valid_o, .out_ready_i, .status_o, .accepted_o, .slot_index_o, .evicted_o,
    .voice_count_o, .top_valid_o, .top_slot_o, .top_id_o, .top_priority_o
  );

  priority_voice_allocator_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_i(in_ready_o), .action_i, .sound_id_i, .priority_req_i,
    .payload_i, .out_valid_i(out_valid_o), .out_ready_i, .status_i(status_o),
    .accepted_i(accepted_o), .slot_index_i(slot_index_o), .evicted_i(evicted_o),
    .voice_count_i(voice_count_o), .top_valid_i(top_valid_o), .top_slot_i(top_slot_o),
    .top_id_i(top_id_o), .top_priority_i(top_priority_o),
    .fails_o(fails), .pending_o(pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // offers one event and returns at the edge of its transfer
  task automatic push_event(input logic [2:0] act, input logic [15:0] sid,
                            input logic [15:0] pri, input logic [31:0] pay);
    int gap;
    if (burst_left == 0) begin
      gap = no_gaps ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    action_i <= act;
    sound_id_i <= sid;
    priority_req_i <= pri;
    payload_i <= pay;
    items_sent++;
    if (items_sent == HoldAtItem) hold_go = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic write_channels(input logic [4:0] chans);
    cfg_wdata_i <= chans;
    cfg_we_i <= 1'b1;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [15:0] pick_priority();
    case ($urandom_range(0, 3))
      0:       return 16'($urandom_range(0, 7));
      1:       return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [4:0] pick_channels();
    case ($urandom_range(0, 9))
      0:       return 5'd0;
      1:       return 5'd1;
      2:       return 5'd16;
      3:       return 5'd31;
      4:       return 5'($urandom_range(17, 30));
      default: return 5'($urandom_range(2, 15));
    endcase
  endfunction

  // one request inside an open frame, mostly well formed
  task automatic push_request();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 45)
      push_event(pva_pkg::ActStart, 16'($urandom_range(1, 16'hFFFF)), pick_priority(),
                 $urandom);
    else if (pick < 90)
      push_event(pva_pkg::ActUpdate, 16'($urandom_range(1, 16'hFFFF)), pick_priority(),
                 $urandom);
    else if (pick < 94)
      push_event(pva_pkg::ActStop, 16'($urandom_range(1, 16'hFFFF)), pick_priority(),
                 $urandom);
    else if (pick < 97)
      push_event(3'($urandom_range(pva_pkg::ActStart, pva_pkg::ActStop)), '0,
                 pick_priority(), $urandom);
    else if (pick < 98)
      push_event(pva_pkg::ActBegin, 16'($urandom), 16'($urandom), $urandom);
    else
      push_event(3'($urandom_range(ActUnusedLo, ActUnusedHi)), 16'($urandom),
                 16'($urandom), $urandom);
  endtask

  initial begin : receiver
    int mode;
    int left;
    int hold_left;
    int tick;
    mode = 0;
    left = 0;
    hold_left = 0;
    tick = 0;
    forever begin
      @(posedge clk_i);
      if (hold_go && !hold_used) begin
        hold_used = 1'b1;
        hold_left = HoldCycles;
        out_ready_i <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(20, 120);
        end
        left--;
        tick++;
        case (mode)
          0:       out_ready_i <= 1'b1;
          1:       out_ready_i <= 1'($urandom_range(0, 1));
          2:       out_ready_i <= ($urandom_range(0, 3) == 0);
          default: out_ready_i <= (tick % 5) != 0;
        endcase
      end
    end
  end

  initial begin : stimulus
    int phase_end;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // two slots: framing errors, fill, ties and stealing
    write_channels(5'd2);
    push_event(pva_pkg::ActStart, 16'd5, 16'd10, 32'd1);
    push_event(pva_pkg::ActEnd, '0, '0, '0);
    push_event(pva_pkg::ActBegin, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    push_event(pva_pkg::ActBegin, '0, '0, '0);
    push_event(pva_pkg::ActStart, '0, 16'd7, '0);
    push_event(pva_pkg::ActUpdate, '0, 16'd7, '0);
    push_event(pva_pkg::ActStop, '0, 16'd7, '0);
    push_event(pva_pkg::ActStart, 16'hFFFF, 16'h0000, 32'hFFFF_FFFF);
    push_event(pva_pkg::ActUpdate, 16'h0001, 16'h0000, '0);
    push_event(pva_pkg::ActStart, 16'h0002, 16'h0000, 32'h1234_5678);
    push_event(pva_pkg::ActStart, 16'h0003, 16'hFFFF, '0);
    push_event(pva_pkg::ActUpdate, 16'h0004, 16'h0001, 32'hA5A5_5A5A);
    push_event(pva_pkg::ActStop, 16'h0007, 16'hFFFF, '0);
    push_event(ActUnusedLo, 16'h0008, 16'h0008, 32'h8);
    push_event(ActUnusedHi, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    push_event(pva_pkg::ActEnd, '0, '0, '0);
    push_event(pva_pkg::ActStop, 16'd3, '0, '0);

    // no slots at all
    drain_results();
    write_channels(5'd0);
    push_event(pva_pkg::ActBegin, '0, '0, '0);
    push_event(pva_pkg::ActStart, 16'd9, 16'hFFFF, 32'd9);
    push_event(pva_pkg::ActEnd, '0, '0, '0);

    // oversized setting, then capacity lowered inside an open frame
    drain_results();
    write_channels(5'd31);
    push_event(pva_pkg::ActBegin, '0, '0, '0);
    push_event(pva_pkg::ActStart, 16'd11, 16'd100, 32'd11);
    push_event(pva_pkg::ActStart, 16'd12, 16'd50, 32'd12);
    push_event(pva_pkg::ActUpdate, 16'd13, 16'd200, 32'd13);
    drain_results();
    write_channels(5'd1);
    push_event(pva_pkg::ActStart, 16'd14, 16'd60, 32'd14);
    push_event(pva_pkg::ActUpdate, 16'd15, 16'd10, 32'd15);
    push_event(pva_pkg::ActEnd, '0, '0, '0);

    while (items_sent < ItemTarget) begin
      drain_results();
      write_channels(pick_channels());
      no_gaps = ($urandom_range(0, 3) == 0);
      phase_end = items_sent + $urandom_range(40, 120);
      while (items_sent < phase_end) begin
        if ($urandom_range(0, 6) == 0) begin
          repeat ($urandom_range(1, 6))
            push_event(3'($urandom), 16'($urandom), 16'($urandom), $urandom);
        end else begin
          push_event(pva_pkg::ActBegin, 16'($urandom), 16'($urandom), $urandom);
          repeat ($urandom_range(0, 24)) push_request();
          if ($urandom_range(0, 9) != 0)
            push_event(pva_pkg::ActEnd, 16'($urandom), 16'($urandom), $urandom);
        end
      end
    end

    drain_results();
    repeat (2 * ItemCycles) @(posedge clk_i);
    if (fails == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+sv
sv/pva_pkg.sv
sv/pva_cell.sv
sv/priority_voice_allocator_unit.sv
tb/priority_voice_allocator_checker.sv
tb/priority_voice_allocator_unit_tb.sv
